### src/bfa_pkg.sv
// shared types and constants for the first-fit block table allocator
package bfa_pkg;

    // one table entry: start, contiguous and allocated marks
    localparam int ENTRY_W         = 3;
    localparam int MARK_ALLOC_BIT  = 0;
    localparam int MARK_CONTIG_BIT = 1;
    localparam int MARK_START_BIT  = 2;

    // request and result field widths
    localparam int DATA_W   = 32;
    localparam int LG_W     = 5;
    localparam int STATUS_W = 2;

    // effective block size range
    localparam logic [LG_W-1:0] LG_MIN   = 5'd2;
    localparam logic [LG_W-1:0] LG_MAX   = 5'd16;
    localparam logic [LG_W-1:0] LG_RESET = 5'd12;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_ADDR,
        S_DONE
    } state_t;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_ROUND,
        ALU_INDEX,
        ALU_ADDR
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [DATA_W-1:0] op_a;
        logic [DATA_W-1:0] op_b;
        logic [LG_W-1:0]   shamt;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W:0] value;
        logic            borrow;
    } alu_rsp_t;

endpackage

### src/bfa_ram.sv
// generic single write port, single read port ram with registered read
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### src/bfa_alu.sv
// shared add and shift unit: size round-up, address to index, index to address
module bfa_alu import bfa_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [DATA_W:0] mask;
    logic [DATA_W:0] op1;
    logic [DATA_W:0] op2;
    logic [DATA_W:0] sum;
    logic            cin;

    // operand selection and the one adder
    always_comb begin
        mask = (33'd1 << req.shamt) - 33'd1;
        op1  = {1'b0, req.op_a};
        op2  = '0;
        cin  = 1'b0;
        case (req.op)
            ALU_ROUND: begin
                op2 = mask;
            end
            ALU_INDEX: begin
                op2 = {1'b1, ~req.op_b};
                cin = 1'b1;
            end
            ALU_ADDR: begin
                op1 = {1'b0, req.op_a << req.shamt};
                op2 = {1'b0, req.op_b};
            end
            default: begin
                op2 = '0;
            end
        endcase
        sum = op1 + op2 + {{DATA_W{1'b0}}, cin};
    end

    // post shift
    always_comb begin
        case (req.op)
            ALU_ROUND: rsp.value = sum >> req.shamt;
            ALU_INDEX: rsp.value = {1'b0, sum[DATA_W-1:0]} >> req.shamt;
            default:   rsp.value = {1'b0, sum[DATA_W-1:0]};
        endcase
        rsp.borrow = sum[DATA_W];
    end

endmodule

### src/block_table_first_fit_allocator.sv
// first-fit heap allocator over a block table, top level and sequencer
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  request | s_valid s_ready s_action s_size_bytes       | in
//          | s_address                                  |
//  result  | m_valid m_ready m_status m_block_address    | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data      | in
//
// after reset the table is swept to zero before the first request beat
// allocate: setup, then the first-fit walk, which reads one table entry per cycle,
//   then the run marks are written and the block address is formed
// free: setup, then the run is cleared, one entry cleared per cycle
// one request at a time; a finished result sits in the output register, so the next
//   request beat is taken while it waits
module block_table_first_fit_allocator import bfa_pkg::*; #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [DATA_W-1:0]     s_size_bytes,
    input  logic [DATA_W-1:0]     s_address,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [DATA_W-1:0]     m_block_address,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0]  N_CNT    = CNT_W'(NUM_BLOCKS);
    localparam logic [DATA_W:0]   N_WIDE   = (DATA_W + 1)'(NUM_BLOCKS);

    // configuration registers
    logic [DATA_W-1:0] heap_base_reg;
    logic [LG_W-1:0]   lg_cfg_reg;
    logic [LG_W-1:0]   lg_eff;

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic                action_reg;
    logic [DATA_W-1:0]   size_reg;
    logic [DATA_W-1:0]   addr_reg;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [IDX_W-1:0]    first_reg, first_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]    mark_cnt_reg, mark_cnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   res_addr_reg, res_addr_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_addr_reg, m_addr_next;

    // table ram and shared unit
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic [CNT_W-1:0]    run_inc;
    logic [CNT_W-1:0]    mark_inc;

    bfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    bfa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // effective block size, clamped
    always_comb begin
        if (lg_cfg_reg < LG_MIN) begin
            lg_eff = LG_MIN;
        end else if (lg_cfg_reg > LG_MAX) begin
            lg_eff = LG_MAX;
        end else begin
            lg_eff = lg_cfg_reg;
        end
    end

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            lg_cfg_reg    <= LG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HEAP_BASE:  heap_base_reg <= cfg_data;
                CFG_BLOCK_LOG2: lg_cfg_reg    <= cfg_data[LG_W-1:0];
                default:        lg_cfg_reg    <= lg_cfg_reg;
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_block_address = m_addr_reg;
    assign run_inc         = run_reg + CNT_W'(1);
    assign mark_inc        = mark_cnt_reg + CNT_W'(1);

    // next state, shared unit requests and table writes
    always_comb begin
        state_next    = state_reg;
        need_next     = need_reg;
        first_next    = first_reg;
        run_next      = run_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        mark_cnt_next = mark_cnt_reg;
        status_next   = status_reg;
        res_addr_next = res_addr_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg;
        ram_wdata     = '0;
        alu_req.op    = ALU_ROUND;
        alu_req.op_a  = size_reg;
        alu_req.op_b  = heap_base_reg;
        alu_req.shamt = lg_eff;

        // result register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // sweep the table to zero after reset
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_waddr   = rd_ptr_reg[IDX_W-1:0];
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                if (rd_ptr_reg[IDX_W-1:0] == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                res_addr_next = '0;
                if (s_valid) begin
                    state_next = S_SETUP;
                end
            end

            // round size up to blocks, or turn the address into an index
            S_SETUP: begin
                run_next  = '0;
                pend_next = 1'b0;
                if (action_reg == ACT_ALLOC) begin
                    alu_req.op = ALU_ROUND;
                    alu_req.op_a = size_reg;
                    if (alu_rsp.value == '0) begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end else if (alu_rsp.value > N_WIDE) begin
                        status_next = ST_NOMEM;
                        state_next  = S_DONE;
                    end else begin
                        need_next   = alu_rsp.value[CNT_W-1:0];
                        rd_ptr_next = '0;
                        state_next  = S_SCAN;
                    end
                end else begin
                    alu_req.op   = ALU_INDEX;
                    alu_req.op_a = addr_reg;
                    if (alu_rsp.borrow || (alu_rsp.value >= N_WIDE)) begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end else begin
                        rd_ptr_next = alu_rsp.value[CNT_W-1:0];
                        state_next  = S_FREE;
                    end
                end
            end

            // first-fit walk, one entry read per cycle
            S_SCAN: begin
                if (rd_ptr_reg < N_CNT) begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    if (ram_rdata[MARK_ALLOC_BIT]) begin
                        run_next = '0;
                    end else begin
                        if (run_reg == '0) begin
                            first_next = pend_idx_reg;
                        end
                        run_next = run_inc;
                    end
                    if (!ram_rdata[MARK_ALLOC_BIT] && (run_inc == need_reg)) begin
                        mark_cnt_next = '0;
                        pend_next     = 1'b0;
                        state_next    = S_MARK;
                    end else if (pend_idx_reg == LAST_IDX) begin
                        status_next = ST_NOMEM;
                        pend_next   = 1'b0;
                        state_next  = S_DONE;
                    end
                end
            end

            // write the run marks, one entry per cycle
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = first_reg + mark_cnt_reg[IDX_W-1:0];
                ram_wdata[MARK_ALLOC_BIT]  = 1'b1;
                ram_wdata[MARK_START_BIT]  = (mark_cnt_reg == '0);
                ram_wdata[MARK_CONTIG_BIT] = (mark_inc != need_reg);
                mark_cnt_next = mark_inc;
                if (mark_inc == need_reg) begin
                    state_next = S_ADDR;
                end
            end

            // clear entries up to and including the first one without the contiguous mark, or the last entry
            S_FREE: begin
                if (rd_ptr_reg < N_CNT) begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg;
                    if (!ram_rdata[MARK_CONTIG_BIT] || (pend_idx_reg == LAST_IDX)) begin
                        status_next = ST_DONE;
                        pend_next   = 1'b0;
                        state_next  = S_DONE;
                    end
                end
            end

            // base plus index times block size
            S_ADDR: begin
                alu_req.op    = ALU_ADDR;
                alu_req.op_a  = DATA_W'(first_reg);
                res_addr_next = alu_rsp.value[DATA_W-1:0];
                status_next   = ST_DONE;
                state_next    = S_DONE;
            end

            // hand over to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            rd_ptr_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            size_reg   <= s_size_bytes;
            addr_reg   <= s_address;
        end
        need_reg     <= need_next;
        first_reg    <= first_next;
        run_reg      <= run_next;
        pend_idx_reg <= pend_idx_next;
        mark_cnt_reg <= mark_cnt_next;
        status_reg   <= status_next;
        res_addr_reg <= res_addr_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
    end

    // a failed result never carries an address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_DONE)) |-> (m_block_address == '0))
        else $error("nonzero address on a failed result");

    // only one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while busy");

    // no request beat during the table sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("request taken during table sweep");

    // run marking stays inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK) |->
            (((CNT_W + 1)'(first_reg) + (CNT_W + 1)'(mark_cnt_reg)) < (CNT_W + 1)'(NUM_BLOCKS)))
        else $error("run marking past end of table");

endmodule
